[rtl/grid_line_of_sight_unit_defines.svh]
// Assertion macros shared by the line of sight block.
`ifndef GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GLOS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/glos_pkg.sv]
// Package with the word types and fixed constants of the line of sight block.
package glos_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int PT_W       = 14;
	localparam int DIM_W      = 7;
	localparam int TIDX_W     = 12;
	localparam int SCALE_SH   = 8;
	localparam int MARCH_FRAC = FRAC_BITS + SCALE_SH;
	localparam int TILE_W     = PT_W - FRAC_BITS;
	localparam int IDX_W      = TILE_W + DIM_W;
	localparam int NUM_W      = PT_W + SCALE_SH;
	localparam int POS_W      = NUM_W + 1;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [DIM_W-1:0] MAP_DIM_RESET = 7'd64;

	typedef struct packed {
		logic              mode;
		logic [TIDX_W-1:0] tile_index;
		logic              tile_solid;
		logic [PT_W-1:0]   start_x;
		logic [PT_W-1:0]   start_y;
		logic [PT_W-1:0]   end_x;
		logic [PT_W-1:0]   end_y;
	} in_word_t;

	typedef struct packed {
		logic line_clear;
		logic out_of_map;
	} out_word_t;

endpackage

[rtl/grid_line_of_sight_unit.sv]
// Top level of the line of sight block: tile store, step divider and march sequencer.
//
// Input words arrive on in_valid/in_stall, results leave on out_valid/out_stall.
// A word with mode 0 writes one tile bit into the tile store in the cycle it is
// accepted and produces no result; the block is ready again at once.
// A word with mode 1 runs a query. The per-axis step is the span divided by
// SAMPLE_COUNT, formed by one shared multiplier with a scaled reciprocal, x
// before y. The march then issues one sample per cycle to the tile store, whose
// registered read data is judged together with the registered outside flag.
// A clear line runs through all SAMPLE_COUNT samples before its result is
// formed; a line that hits a solid or outside tile ends as soon as that
// sample is judged.
// in_stall is high from acceptance of a query until its result has been moved
// into the output register. A result waits there while out_stall is high, and
// the block may accept a tile write or a new query meanwhile; a query that
// finishes while the old result still waits holds until it is taken.
// Reset clears the control state and sets the map to 64 by 64 tiles. The tile
// store is not cleared: every tile must be written before a query reads it.
// Configuration writes are taken in any cycle and must only be made while idle.
module grid_line_of_sight_unit #(
	parameter int MAP_TILES    = 4096,
	parameter int SAMPLE_COUNT = 100
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [glos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [glos_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  glos_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output glos_pkg::out_word_t            out_data
);

	`include "grid_line_of_sight_unit_defines.svh"

	import glos_pkg::*;

	localparam int     AW      = $clog2(MAP_TILES);
	localparam int     DIV_SH  = NUM_W + $clog2(SAMPLE_COUNT);
	localparam int     QUOT_SH = DIV_SH - SCALE_SH;
	localparam int     RECIP_W = NUM_W + 1;
	localparam int     PROD_W  = PT_W + RECIP_W;
	localparam int     KW      = $clog2(SAMPLE_COUNT + 1);
	localparam longint RECIP   = ((longint'(1) << DIV_SH) + longint'(SAMPLE_COUNT)
		- longint'(1)) / longint'(SAMPLE_COUNT);
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIV    = 4'b0010,
		ST_MARCH  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] map_width_q;
	logic [DIM_W-1:0] map_height_q;
	logic             cnt_q;
	logic [KW-1:0]    k_q;
	logic             iss_q;
	logic             vld_s0;
	logic             vld_s1;
	logic             last_s0;
	logic             last_s1;
	logic             out_s1;
	logic             out_valid_q;
	out_word_t        res_q;
	out_word_t        out_q;

	logic [POS_W-1:0] c_x_q;
	logic [POS_W-1:0] c_y_q;
	logic [POS_W-1:0] e_x_q;
	logic [POS_W-1:0] e_y_q;
	logic [PT_W-1:0]  d_x_q;
	logic [PT_W-1:0]  d_y_q;
	logic [NUM_W-1:0] n_x_q;
	logic [NUM_W-1:0] n_y_q;
	logic             neg_x_q;
	logic             neg_y_q;

	logic             accept;
	logic             query_acc;
	logic [PT_W-1:0]  diff_x;
	logic [PT_W-1:0]  diff_y;
	logic [PT_W-1:0]  div_in;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0] quot;
	logic [POS_W-1:0] step_x;
	logic [POS_W-1:0] step_y;
	logic             last_iss;
	logic [POS_W-1:0] p_x;
	logic [POS_W-1:0] p_y;
	logic [TILE_W-1:0] tx;
	logic [TILE_W-1:0] ty;
	logic [IDX_W-1:0] idx;
	logic             outside_s0;
	logic [IDX_W+AW-1:0] raddr_wide;
	logic [TIDX_W+AW-1:0] waddr_wide;
	logic             ram_we;
	logic [0:0]       rd_data;
	logic             hit_s1;
	logic             done_s1;
	logic             out_free;

	assign accept    = in_valid && !in_stall;
	assign query_acc = accept && (in_data.mode == MODE_QUERY);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign diff_x = (in_data.end_x >= in_data.start_x) ? (in_data.end_x - in_data.start_x)
		: (in_data.start_x - in_data.end_x);
	assign diff_y = (in_data.end_y >= in_data.start_y) ? (in_data.end_y - in_data.start_y)
		: (in_data.start_y - in_data.end_y);

	assign div_in = (cnt_q == 1'b0) ? d_x_q : d_y_q;
	assign prod   = PROD_W'(div_in) * PROD_W'(RECIP_C);
	assign quot   = NUM_W'(prod >> QUOT_SH);

	assign step_x = neg_x_q ? (~{1'b0, n_x_q} + POS_W'(1)) : {1'b0, n_x_q};
	assign step_y = neg_y_q ? (~{1'b0, n_y_q} + POS_W'(1)) : {1'b0, n_y_q};

	assign last_iss = (k_q == KW'(SAMPLE_COUNT));
	assign p_x      = last_iss ? e_x_q : (c_x_q + step_x);
	assign p_y      = last_iss ? e_y_q : (c_y_q + step_y);

	assign tx  = c_x_q[MARCH_FRAC +: TILE_W];
	assign ty  = c_y_q[MARCH_FRAC +: TILE_W];
	assign idx = IDX_W'(ty) * IDX_W'(map_width_q) + IDX_W'(tx);
	assign outside_s0 = ({1'b0, tx} >= map_width_q) || ({1'b0, ty} >= map_height_q)
		|| (32'(idx) >= MAP_TILES);

	assign raddr_wide = {{AW{1'b0}}, idx};
	assign waddr_wide = {{AW{1'b0}}, in_data.tile_index};
	assign ram_we     = accept && (in_data.mode == MODE_WRITE)
		&& (32'(in_data.tile_index) < MAP_TILES);

	assign hit_s1  = out_s1 || rd_data[0];
	assign done_s1 = vld_s1 && (hit_s1 || last_s1);

	glos_ram #(
		.WIDTH (1),
		.DEPTH (MAP_TILES)
	) u_tile_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_wide[AW-1:0]),
		.wdata (in_data.tile_solid),
		.raddr (raddr_wide[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			map_width_q  <= MAP_DIM_RESET;
			map_height_q <= MAP_DIM_RESET;
			cnt_q        <= 1'b0;
			k_q          <= '0;
			iss_q        <= 1'b0;
			vld_s0       <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAP_WIDTH: map_width_q <= cfg_data;
					REG_MAP_HEIGHT: map_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						state_q <= ST_DIV;
						cnt_q   <= 1'b0;
					end
				end
				ST_DIV: begin
					cnt_q <= 1'b1;
					if (cnt_q) begin
						state_q <= ST_MARCH;
						iss_q   <= 1'b1;
						k_q     <= KW'(1);
					end
				end
				ST_MARCH: begin
					if (done_s1) begin
						state_q <= ST_FINISH;
						iss_q   <= 1'b0;
						vld_s0  <= 1'b0;
						vld_s1  <= 1'b0;
					end else begin
						vld_s1 <= vld_s0;
						vld_s0 <= iss_q;
						if (iss_q) begin
							k_q <= k_q + KW'(1);
							if (last_iss) begin
								iss_q <= 1'b0;
							end
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			c_x_q   <= {1'b0, in_data.start_x, {SCALE_SH{1'b0}}};
			c_y_q   <= {1'b0, in_data.start_y, {SCALE_SH{1'b0}}};
			e_x_q   <= {1'b0, in_data.end_x, {SCALE_SH{1'b0}}};
			e_y_q   <= {1'b0, in_data.end_y, {SCALE_SH{1'b0}}};
			d_x_q   <= diff_x;
			d_y_q   <= diff_y;
			neg_x_q <= (in_data.end_x < in_data.start_x);
			neg_y_q <= (in_data.end_y < in_data.start_y);
		end
		if (state_q == ST_DIV) begin
			if (cnt_q == 1'b0) begin
				n_x_q <= quot;
			end else begin
				n_y_q <= quot;
			end
		end
		if (state_q == ST_MARCH && iss_q) begin
			c_x_q   <= p_x;
			c_y_q   <= p_y;
			last_s0 <= last_iss;
		end
		out_s1  <= outside_s0;
		last_s1 <= last_s0;
		if (state_q == ST_MARCH && done_s1) begin
			res_q.line_clear <= !hit_s1;
			res_q.out_of_map <= out_s1;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q <= res_q;
		end
	end

	`GLOS_ASSERT_NEXT(a_result_from_finish, clk, arst_n,
		(state_q == ST_FINISH) && out_free, out_valid_q && (state_q == ST_IDLE),
		"finished query did not reach the output register")
	`GLOS_ASSERT_SAME(a_pipe_only_in_march, clk, arst_n,
		vld_s0 || vld_s1 || iss_q, state_q == ST_MARCH,
		"sample pipeline active outside the march")
	`GLOS_ASSERT_NEXT(a_query_starts_divide, clk, arst_n,
		query_acc, (state_q == ST_DIV) && (cnt_q == 1'b0),
		"accepted query did not start the divider")

endmodule

[rtl/glos_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module glos_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[dv/grid_line_of_sight_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the grid line of sight unit against a shadow tile map.
module grid_line_of_sight_unit_tb;
	import glos_pkg::*;

	localparam int TILES       = 4096;
	localparam int FILL_TILES  = 128;
	localparam int SAMPLES     = 100;
	localparam int PT_MAX      = (1 << PT_W) - 1;
	localparam int DRAIN_WAIT  = 200;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [DIM_W-1:0] MAP_DIM_MAX = '1;

	typedef enum int {
		PROBE_OPEN,
		PROBE_SOLID,
		PROBE_OUTSIDE
	} probe_e;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_word_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_word_t            out_data;

	logic             tile_map [TILES];
	logic [DIM_W-1:0] map_cols;
	logic [DIM_W-1:0] map_rows;
	out_word_t        pending_sight [$];
	int               error_count;
	int               cycle_count;
	int               tx_idle_pct;
	int               rx_idle_pct;

	grid_line_of_sight_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin : check_sight
		out_word_t expected_sight;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sight.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual clear %0b outside %0b",
					$time, out_data.line_clear, out_data.out_of_map);
				error_count++;
			end else begin
				expected_sight = pending_sight.pop_front();
				if (out_data.line_clear !== expected_sight.line_clear) begin
					$display("%0t: line_clear mismatch, expected %0b, actual %0b",
						$time, expected_sight.line_clear, out_data.line_clear);
					error_count++;
				end
				if (out_data.out_of_map !== expected_sight.out_of_map) begin
					$display("%0t: out_of_map mismatch, expected %0b, actual %0b",
						$time, expected_sight.out_of_map, out_data.out_of_map);
					error_count++;
				end
			end
		end
	end

	function automatic out_word_t predict_sight(input in_word_t w);
		longint    sx, sy, ex, ey, stx, sty, cx, cy, tx, ty, idx, cols, rows;
		probe_e    hit;
		out_word_t r;
		cols = map_cols;
		rows = map_rows;
		sx   = longint'(w.start_x) << SCALE_SH;
		sy   = longint'(w.start_y) << SCALE_SH;
		ex   = longint'(w.end_x) << SCALE_SH;
		ey   = longint'(w.end_y) << SCALE_SH;
		stx  = (ex - sx) / SAMPLES;
		sty  = (ey - sy) / SAMPLES;
		hit  = PROBE_OPEN;
		for (int k = 1; k <= SAMPLES; k++) begin
			if (k == SAMPLES) begin
				cx = ex;
				cy = ey;
			end else begin
				cx = sx + k * stx;
				cy = sy + k * sty;
			end
			tx = cx >>> MARCH_FRAC;
			ty = cy >>> MARCH_FRAC;
			if (tx >= cols || ty >= rows) begin
				hit = PROBE_OUTSIDE;
			end else begin
				idx = ty * cols + tx;
				if (idx >= TILES)
					hit = PROBE_OUTSIDE;
				else
					hit = tile_map[idx] ? PROBE_SOLID : PROBE_OPEN;
			end
			if (hit != PROBE_OPEN)
				break;
		end
		r.line_clear = (hit == PROBE_OPEN);
		r.out_of_map = (hit == PROBE_OUTSIDE);
		return r;
	endfunction

	function automatic int clamp_point(input int v);
		return (v < 0) ? 0 : ((v > PT_MAX) ? PT_MAX : v);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return DIM_W'(1);
			2: return '1;
			3, 4: return DIM_W'($urandom_range(64, 1));
			5: return DIM_W'($urandom());
			default: return MAP_DIM_RESET;
		endcase
	endfunction

	task automatic send_word(input in_word_t w);
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (w.mode == MODE_WRITE)
			tile_map[w.tile_index] = w.tile_solid;
		else
			pending_sight.insert(pending_sight.size(), predict_sight(w));
	endtask

	task automatic put_tile(input int idx, input logic solid);
		in_word_t w;
		w.mode       = MODE_WRITE;
		w.tile_index = TIDX_W'(idx);
		w.tile_solid = solid;
		w.start_x    = PT_W'($urandom());
		w.start_y    = PT_W'($urandom());
		w.end_x      = PT_W'($urandom());
		w.end_y      = PT_W'($urandom());
		send_word(w);
	endtask

	task automatic ask_sight(input int sx, input int sy, input int ex, input int ey);
		in_word_t w;
		w.mode       = MODE_QUERY;
		w.tile_index = TIDX_W'($urandom());
		w.tile_solid = 1'($urandom());
		w.start_x    = PT_W'(sx);
		w.start_y    = PT_W'(sy);
		w.end_x      = PT_W'(ex);
		w.end_y      = PT_W'(ey);
		send_word(w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sight.size() != 0 || in_stall) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAP_WIDTH)
			map_cols = val;
		else
			map_rows = val;
	endtask

	task automatic set_map_dims(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
		wait_drained();
		write_reg(REG_MAP_WIDTH, cols);
		write_reg(REG_MAP_HEIGHT, rows);
	endtask

	// Random writes hit only the first FILL_TILES tiles, so the map never spans more.
	task automatic pick_map();
		logic [DIM_W-1:0] cols;
		int               lim;
		cols = pick_dim();
		lim  = (cols == '0) ? int'(MAP_DIM_MAX) : (FILL_TILES / int'(cols));
		if (lim > int'(MAP_DIM_MAX))
			lim = int'(MAP_DIM_MAX);
		case ($urandom_range(3))
			0: set_map_dims(cols, '0);
			1: set_map_dims(cols, DIM_W'(lim));
			default: set_map_dims(cols, DIM_W'($urandom_range(lim)));
		endcase
	endtask

	task automatic test_tile_fill(input int solid_pct);
		for (int i = 0; i < FILL_TILES; i++)
			put_tile(i, $urandom_range(99) < solid_pct);
	endtask

	task automatic test_blocking();
		put_tile(TILES - 1, 1'b1);
		put_tile(0, 1'b0);
		put_tile(64 + 10, 1'b1);
		ask_sight(0, 0, 0, 0);
		ask_sight(0, 0, PT_MAX, 0);
		ask_sight(PT_MAX, 0, 0, 256 + 128);
		// The start lies in a solid tile but is never sampled.
		ask_sight(10 * 256 + 250, 256 + 128, 50 * 256, 256 + 128);
		ask_sight(0, 256 + 128, 20 * 256, 256 + 128);
		ask_sight(PT_MAX, 511, 0, 0);
	endtask

	task automatic test_map_bounds();
		set_map_dims(8, 64);
		ask_sight(0, 0, 12 * 256, 0);
		set_map_dims(64, 0);
		ask_sight(0, 0, 0, 0);
		set_map_dims(0, 64);
		ask_sight(128, 128, 128, 128);
		set_map_dims('1, '1);
		ask_sight(0, 0, PT_MAX, 0);
		ask_sight(0, 40 * 256, 5 * 256, 40 * 256);
		set_map_dims(1, 1);
		ask_sight(10, 20, 200, 250);
		ask_sight(0, 0, 300, 0);
		set_map_dims(MAP_DIM_RESET, MAP_DIM_RESET);
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int items);
		int sx, sy, ex, ey;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		pick_map();
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(49) == 0)
				pick_map();
			if ($urandom_range(9) < 4) begin
				put_tile($urandom_range(FILL_TILES - 1), $urandom_range(3) == 0);
			end else begin
				if ($urandom_range(1) == 0) begin
					sx = clamp_point(int'($urandom_range(int'(map_cols) * 256)));
					sy = clamp_point(int'($urandom_range(int'(map_rows) * 256)));
				end else begin
					sx = $urandom_range(PT_MAX);
					sy = $urandom_range(PT_MAX);
				end
				ex = $urandom_range(PT_MAX);
				ey = $urandom_range(PT_MAX);
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						ex = clamp_point(sx + int'($urandom_range(1536)) - 768);
						ey = clamp_point(sy + int'($urandom_range(1536)) - 768);
					end
					4, 5: ey = sy;
					6: ex = sx;
					7: begin
						ex = sx;
						ey = sy;
					end
					default: ;
				endcase
				ask_sight(sx, sy, ex, ey);
			end
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_stall   = 1'b0;
		map_cols    = MAP_DIM_RESET;
		map_rows    = MAP_DIM_RESET;
		error_count = 0;
		cycle_count = 0;
		tx_idle_pct = 9;
		rx_idle_pct = 77;
		for (int i = 0; i < TILES; i++)
			tile_map[i] = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_tile_fill(0);
		test_blocking();
		test_map_bounds();
		test_tile_fill(15);
		test_random_phase(9, 77, 50);
		test_random_phase(77, 9, 50);
		test_random_phase(0, 0, 50);
		wait_drained();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
